// ===== sv/wtht_pkg.sv =====
`timescale 1ns / 1ps

package wtht_pkg;

    localparam int STATUS_BITS = 16;
    localparam int ID_BITS     = 32;
    localparam int RANK_BITS   = 32;
    localparam int RCNT_BITS   = 31;

    localparam logic [RANK_BITS-1:0] RANK_MINIMIZED = '1;
    localparam logic [RCNT_BITS-1:0] RANK_MAX       = '1;

    typedef enum logic [2:0] {
        OP_CREATE   = 3'd0,
        OP_CLOSE    = 3'd1,
        OP_FOCUS    = 3'd2,
        OP_MINIMIZE = 3'd3,
        OP_RESIZE   = 3'd4,
        OP_MOVE     = 3'd5,
        OP_HIT      = 3'd6,
        OP_STATUS   = 3'd7
    } t_op;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_COMMIT
    } t_state;

    typedef struct packed {
        logic clear;
        logic check;
        logic used;
    } t_scan_ctl;

    typedef struct packed {
        logic match;
        logic free;
        logic hit;
    } t_scan_flags;

endpackage

// ===== sv/wtht_ram.sv =====
`timescale 1ns / 1ps

module wtht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/wtht_scan.sv =====
`timescale 1ns / 1ps

module wtht_scan #(
    parameter int SLOTS      = 16,
    parameter int COORD_BITS = 16,
    localparam int IW        = (SLOTS > 1) ? $clog2(SLOTS) : 1,
    localparam int EW        = 64 + 4 * COORD_BITS
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  wtht_pkg::t_scan_ctl     i_ctl,
    input  logic [IW-1:0]           i_idx,
    input  logic [EW-1:0]           i_entry,
    input  logic [31:0]             i_window_id,
    input  logic [COORD_BITS-1:0]   i_pos_x,
    input  logic [COORD_BITS-1:0]   i_pos_y,
    output wtht_pkg::t_scan_flags   o_flags,
    output logic [IW-1:0]           o_match_idx,
    output logic [IW-1:0]           o_free_idx,
    output logic [EW-1:0]           o_match_entry,
    output logic [31:0]             o_hit_id
);

    import wtht_pkg::*;

    localparam int CB   = COORD_BITS;
    localparam int H_LO = RANK_BITS;
    localparam int W_LO = H_LO + CB;
    localparam int T_LO = W_LO + CB;
    localparam int L_LO = T_LO + CB;
    localparam int I_LO = L_LO + CB;

    t_scan_flags          r_flags;
    logic [IW-1:0]        r_match_idx;
    logic [IW-1:0]        r_free_idx;
    logic [EW-1:0]        r_match_entry;
    logic [31:0]          r_hit_id;
    logic [RANK_BITS-1:0] r_hit_rank;

    logic [ID_BITS-1:0]   e_id;
    logic [CB-1:0]        e_left;
    logic [CB-1:0]        e_top;
    logic [CB-1:0]        e_wide;
    logic [CB-1:0]        e_high;
    logic [RANK_BITS-1:0] e_rank;
    logic [CB:0]          e_right;
    logic [CB:0]          e_bottom;
    logic                 id_eq;
    logic                 inside_x;
    logic                 inside_y;
    logic                 visible;

    always_comb begin
        e_id     = i_entry[I_LO +: ID_BITS];
        e_left   = i_entry[L_LO +: CB];
        e_top    = i_entry[T_LO +: CB];
        e_wide   = i_entry[W_LO +: CB];
        e_high   = i_entry[H_LO +: CB];
        e_rank   = i_entry[0 +: RANK_BITS];
        e_right  = {1'b0, e_left} + {1'b0, e_wide};
        e_bottom = {1'b0, e_top} + {1'b0, e_high};
        id_eq    = i_ctl.used && (e_id == i_window_id);
        inside_x = (i_pos_x >= e_left) && ({1'b0, i_pos_x} < e_right);
        inside_y = (i_pos_y >= e_top) && ({1'b0, i_pos_y} < e_bottom);
        visible  = i_ctl.used && (e_rank != RANK_MINIMIZED) && inside_x && inside_y;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear) begin
            r_flags <= '0;
        end else if (i_ctl.check) begin
            if (id_eq && !r_flags.match) begin
                r_flags.match <= 1'b1;
                r_match_idx   <= i_idx;
                r_match_entry <= i_entry;
            end
            if (!i_ctl.used && !r_flags.free) begin
                r_flags.free <= 1'b1;
                r_free_idx   <= i_idx;
            end
            if (visible && (!r_flags.hit || e_rank > r_hit_rank)) begin
                r_flags.hit <= 1'b1;
                r_hit_rank  <= e_rank;
                r_hit_id    <= e_id;
            end
        end
    end

    assign o_flags       = r_flags;
    assign o_match_idx   = r_match_idx;
    assign o_free_idx    = r_free_idx;
    assign o_match_entry = r_match_entry;
    assign o_hit_id      = r_hit_id;

endmodule

// ===== sv/window_table_hit_test.sv =====
`timescale 1ns / 1ps

// Channel  Valid       Ready       Payload
// in       i_in_valid  o_in_ready  i_operation i_window_id i_pos_x i_pos_y i_width i_height
// out      o_out_valid i_out_ready o_ok o_found_id o_status_x o_status_y o_status_width
//                                  o_status_height o_status_rank
//
// One item at a time, set by the single read port of the slot RAM, which is
// swept one slot a cycle per item.
// The commit cycle writes back at most one slot and loads the output register.
// A result waiting on the output stalls only the next commit, not acceptance.
// Reset clears the used bits, slot count and rank counter; no clearing pass.

module window_table_hit_test #(
    parameter int SLOTS      = 16,
    parameter int COORD_BITS = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic [2:0]                            i_operation,
    input  logic [31:0]                           i_window_id,
    input  logic [COORD_BITS-1:0]                 i_pos_x,
    input  logic [COORD_BITS-1:0]                 i_pos_y,
    input  logic [COORD_BITS-1:0]                 i_width,
    input  logic [COORD_BITS-1:0]                 i_height,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic                                  o_ok,
    output logic [31:0]                           o_found_id,
    output logic [wtht_pkg::STATUS_BITS-1:0]      o_status_x,
    output logic [wtht_pkg::STATUS_BITS-1:0]      o_status_y,
    output logic [wtht_pkg::STATUS_BITS-1:0]      o_status_width,
    output logic [wtht_pkg::STATUS_BITS-1:0]      o_status_height,
    output logic signed [31:0]                    o_status_rank
);

    import wtht_pkg::*;

    localparam int CB   = COORD_BITS;
    localparam int IW   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW   = IW + 1;
    localparam int UCW  = $clog2(SLOTS + 1);
    localparam int EW   = 64 + 4 * CB;
    localparam int H_LO = RANK_BITS;
    localparam int W_LO = H_LO + CB;
    localparam int T_LO = W_LO + CB;
    localparam int L_LO = T_LO + CB;

    t_state                r_state;
    t_state                n_state;
    t_op                   r_op;
    logic [31:0]           r_id;
    logic [CB-1:0]         r_px;
    logic [CB-1:0]         r_py;
    logic [CB-1:0]         r_pw;
    logic [CB-1:0]         r_ph;
    logic [CW-1:0]         r_rd_cnt;
    logic                  r_chk_valid;
    logic [IW-1:0]         r_chk_idx;
    logic [SLOTS-1:0]      r_used;
    logic [UCW-1:0]        r_used_count;
    logic [RCNT_BITS-1:0]  r_rank_cnt;

    logic                  r_out_valid;
    logic                  r_ok;
    logic [31:0]           r_found_id;
    logic [STATUS_BITS-1:0] r_sx;
    logic [STATUS_BITS-1:0] r_sy;
    logic [STATUS_BITS-1:0] r_sw;
    logic [STATUS_BITS-1:0] r_sh;
    logic [31:0]           r_srank;

    t_scan_ctl             scan_ctl;
    t_scan_flags           flags;
    logic [IW-1:0]         match_idx;
    logic [IW-1:0]         free_idx;
    logic [EW-1:0]         match_entry;
    logic [31:0]           hit_id;
    logic [EW-1:0]         rd_entry;

    logic                  in_fire;
    logic                  out_free;
    logic                  commit;
    logic                  rd_issue;
    logic                  ok;
    logic                  we;
    logic [IW-1:0]         waddr;
    logic [EW-1:0]         wdata;
    logic                  take_rank;
    logic                  set_used;
    logic                  clr_used;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_fire    = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;
    assign rd_issue   = (r_state == S_SCAN) && (r_rd_cnt < CW'(SLOTS));

    always_comb begin
        scan_ctl.clear = in_fire;
        scan_ctl.check = r_chk_valid;
        scan_ctl.used  = r_used[r_chk_idx];
    end

    wtht_ram #(
        .WIDTH (EW),
        .DEPTH (SLOTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (r_rd_cnt[IW-1:0]),
        .o_rdata (rd_entry)
    );

    wtht_scan #(
        .SLOTS      (SLOTS),
        .COORD_BITS (COORD_BITS)
    ) u_scan (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (scan_ctl),
        .i_idx         (r_chk_idx),
        .i_entry       (rd_entry),
        .i_window_id   (r_id),
        .i_pos_x       (r_px),
        .i_pos_y       (r_py),
        .o_flags       (flags),
        .o_match_idx   (match_idx),
        .o_free_idx    (free_idx),
        .o_match_entry (match_entry),
        .o_hit_id      (hit_id)
    );

    always_comb begin
        n_state = r_state;
        commit  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (!rd_issue && !r_chk_valid) begin
                    n_state = S_COMMIT;
                end
            end
            S_COMMIT: begin
                if (out_free) begin
                    commit  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        ok        = 1'b0;
        take_rank = 1'b0;
        set_used  = 1'b0;
        clr_used  = 1'b0;
        waddr     = match_idx;
        wdata     = match_entry;
        case (r_op)
            OP_CREATE: begin
                ok = !flags.match && flags.free && (r_used_count < UCW'(SLOTS));
                waddr     = free_idx;
                wdata     = {r_id, r_px, r_py, r_pw, r_ph, RANK_BITS'(r_rank_cnt)};
                take_rank = ok;
                set_used  = ok;
            end
            OP_CLOSE: begin
                ok       = flags.match;
                clr_used = ok;
            end
            OP_FOCUS: begin
                ok = flags.match;
                wdata[0 +: RANK_BITS] = RANK_BITS'(r_rank_cnt);
                take_rank = ok;
            end
            OP_MINIMIZE: begin
                ok = flags.match;
                wdata[0 +: RANK_BITS] = RANK_MINIMIZED;
            end
            OP_RESIZE: begin
                ok = flags.match;
                wdata[W_LO +: CB] = r_pw;
                wdata[H_LO +: CB] = r_ph;
            end
            OP_MOVE: begin
                ok = flags.match;
                wdata[L_LO +: CB] = r_px;
                wdata[T_LO +: CB] = r_py;
            end
            OP_HIT: begin
                ok = flags.hit;
            end
            default: begin
                ok = flags.match;
            end
        endcase
        case (r_op) inside
            OP_CLOSE, OP_HIT, OP_STATUS: we = 1'b0;
            default:                     we = commit && ok;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_op <= t_op'(i_operation);
            r_id <= i_window_id;
            r_px <= i_pos_x;
            r_py <= i_pos_y;
            r_pw <= i_width;
            r_ph <= i_height;
        end
        r_chk_idx <= r_rd_cnt[IW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_cnt    <= '0;
            r_chk_valid <= 1'b0;
        end else begin
            r_chk_valid <= rd_issue;
            if (in_fire) begin
                r_rd_cnt <= '0;
            end else if (rd_issue) begin
                r_rd_cnt <= r_rd_cnt + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used       <= '0;
            r_used_count <= '0;
            r_rank_cnt   <= '0;
        end else if (commit) begin
            if (set_used) begin
                r_used[free_idx] <= 1'b1;
                r_used_count     <= r_used_count + UCW'(1);
            end
            if (clr_used) begin
                r_used[match_idx] <= 1'b0;
                if (r_used_count != '0) begin
                    r_used_count <= r_used_count - UCW'(1);
                end
            end
            if (take_rank && r_rank_cnt != RANK_MAX) begin
                r_rank_cnt <= r_rank_cnt + RCNT_BITS'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (commit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (commit) begin
            r_ok       <= ok;
            r_found_id <= (r_op == OP_HIT && ok) ? hit_id : '0;
            if (r_op == OP_STATUS && ok) begin
                r_sx    <= STATUS_BITS'(match_entry[L_LO +: CB]);
                r_sy    <= STATUS_BITS'(match_entry[T_LO +: CB]);
                r_sw    <= STATUS_BITS'(match_entry[W_LO +: CB]);
                r_sh    <= STATUS_BITS'(match_entry[H_LO +: CB]);
                r_srank <= match_entry[0 +: RANK_BITS];
            end else begin
                r_sx    <= '0;
                r_sy    <= '0;
                r_sw    <= '0;
                r_sh    <= '0;
                r_srank <= '0;
            end
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_ok            = r_ok;
    assign o_found_id      = r_found_id;
    assign o_status_x      = r_sx;
    assign o_status_y      = r_sy;
    assign o_status_width  = r_sw;
    assign o_status_height = r_sh;
    assign o_status_rank   = $signed(r_srank);

    a_count_matches_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_used) == int'(r_used_count))
        else $error("slot count disagrees with used bits");

    a_create_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (commit && set_used) |=> (r_used_count == $past(r_used_count) + UCW'(1)))
        else $error("successful create did not add a slot");

    a_rank_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_rank_cnt >= $past(r_rank_cnt)))
        else $error("rank counter went backward");

    a_check_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_chk_valid |-> (r_state == S_SCAN))
        else $error("slot check outside the scan");

    a_write_on_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        we |-> (r_state == S_COMMIT && out_free))
        else $error("slot write outside commit");

endmodule
